// ----- src/lmte_pkg.sv -----
// lmte_pkg: shared types, codes and constants of the lfsr memory test engine
// used by the channel interfaces, the step logic and the top level
package lmte_pkg;

  localparam int unsigned INDEX_BITS_DEF = 20;

  localparam int unsigned LFSR_W    = 24;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned REGION_W  = 21;
  localparam int unsigned WIDX_W    = 20;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = REGION_W;

  localparam logic [LFSR_W-1:0] TOGGLE_MASK = 24'h80042B;
  localparam logic [LFSR_W-1:0] LFSR_TOP    = 24'h800000;
  localparam logic [LFSR_W-1:0] LFSR_MASK   = 24'hFFFFFF;

  localparam logic [REGION_W-1:0] REGION_RESET = 21'h100000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b1;

  // actions
  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_FILL   = 2'd1;
  localparam logic [1:0] ACT_VERIFY = 2'd2;

  // phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FILL   = 2'd1;
  localparam logic [1:0] PH_VERIFY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_SEED = 2'd1;
  localparam logic [1:0] ST_BAD_ACT   = 2'd2;

  // width modes
  localparam logic [1:0] WM_BYTE = 2'd0;
  localparam logic [1:0] WM_HALF = 2'd1;

  typedef struct packed {
    logic [LFSR_W-1:0] lfsr;
    logic [LFSR_W-1:0] seed;
    logic [1:0]        phase;
    logic              had_error;
    logic [CNT_W-1:0]  errors_total;
    logic [CNT_W-1:0]  failed_passes;
    logic [CNT_W-1:0]  clean_passes;
    logic [CNT_W-1:0]  passes_done;
  } state_t;

  typedef struct packed {
    logic [WIDX_W-1:0] word_index;
    logic [LFSR_W-1:0] pattern;
    logic              write_enable;
    logic              mismatch;
    logic              phase_last;
    logic [1:0]        status;
    logic [CNT_W-1:0]  error_count;
    logic [CNT_W-1:0]  bad_passes;
    logic [CNT_W-1:0]  good_passes;
    logic [CNT_W-1:0]  pass_number;
  } rsp_t;

  function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = {v[LFSR_W-2:0], 1'b0};
    if ((v & LFSR_TOP) != '0) begin
      s = s ^ TOGGLE_MASK;
    end
    return s & LFSR_MASK;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ----- src/lmte_req_if.sv -----
// lmte_req_if: request channel into the test engine (action, seed, read data)
// depends on lmte_pkg for field widths
interface lmte_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     action;
  logic [lmte_pkg::LFSR_W-1:0]    seed;
  logic [lmte_pkg::DATA_W-1:0]    read_data;

  modport source (output valid, output action, output seed, output read_data, input ready);
  modport sink   (input valid, input action, input seed, input read_data, output ready);
endinterface

// ----- src/lmte_rsp_if.sv -----
// lmte_rsp_if: result channel out of the test engine
// depends on lmte_pkg for field widths
interface lmte_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lmte_pkg::WIDX_W-1:0]   word_index;
  logic [lmte_pkg::LFSR_W-1:0]   pattern;
  logic                          write_enable;
  logic                          mismatch;
  logic                          phase_last;
  logic [1:0]                    status;
  logic [lmte_pkg::CNT_W-1:0]    error_count;
  logic [lmte_pkg::CNT_W-1:0]    bad_passes;
  logic [lmte_pkg::CNT_W-1:0]    good_passes;
  logic [lmte_pkg::CNT_W-1:0]    pass_number;

  modport source (output valid, output word_index, output pattern, output write_enable,
                  output mismatch, output phase_last, output status, output error_count,
                  output bad_passes, output good_passes, output pass_number, input ready);
  modport sink   (input valid, input word_index, input pattern, input write_enable,
                  input mismatch, input phase_last, input status, input error_count,
                  input bad_passes, input good_passes, input pass_number, output ready);
endinterface

// ----- src/lmte_step.sv -----
// lmte_step: combinational next state and result for one request
// depends on lmte_pkg (state_t, rsp_t, codes, lfsr_advance, sat_inc)
module lmte_step #(
  parameter int unsigned IndexBits = lmte_pkg::INDEX_BITS_DEF
) (
  input  lmte_pkg::state_t                 state_i,
  input  logic [IndexBits-1:0]             word_cnt_i,
  input  logic [lmte_pkg::REGION_W-1:0]    region_i,
  input  logic [1:0]                       width_mode_i,
  input  logic [1:0]                       action_i,
  input  logic [lmte_pkg::LFSR_W-1:0]      seed_i,
  input  logic [lmte_pkg::DATA_W-1:0]      read_data_i,
  output lmte_pkg::state_t                 state_o,
  output logic [IndexBits-1:0]             word_cnt_o,
  output lmte_pkg::rsp_t                   rsp_o
);

  localparam int unsigned RegW = lmte_pkg::REGION_W;
  localparam int unsigned CmpW = ((IndexBits > RegW) ? IndexBits : RegW) + 1;
  localparam int unsigned IdxW = (IndexBits > lmte_pkg::WIDX_W) ? IndexBits : lmte_pkg::WIDX_W;
  localparam logic [CmpW-1:0] MaxWords = CmpW'(1) << IndexBits;

  logic [CmpW-1:0]             region_ext;
  logic [CmpW-1:0]             eff_region;
  logic [CmpW-1:0]             idx_plus1;
  logic [IdxW-1:0]             idx_wide;
  logic [lmte_pkg::LFSR_W-1:0] lfsr_next;
  logic [lmte_pkg::LFSR_W-1:0] pat_mask;
  logic [lmte_pkg::DATA_W-1:0] rd_mask;
  logic [lmte_pkg::LFSR_W-1:0] pat;
  logic                        last;
  logic                        mis;
  logic                        step_ok;

  always_comb begin
    region_ext = CmpW'(region_i);
    if (region_ext == '0) begin
      eff_region = CmpW'(1);
    end else if (region_ext > MaxWords) begin
      eff_region = MaxWords;
    end else begin
      eff_region = region_ext;
    end
  end

  always_comb begin
    case (width_mode_i)
      lmte_pkg::WM_BYTE: begin
        pat_mask = 24'h0000FF;
        rd_mask  = 32'h000000FF;
      end
      lmte_pkg::WM_HALF: begin
        pat_mask = 24'h00FFFF;
        rd_mask  = 32'h0000FFFF;
      end
      default: begin
        pat_mask = lmte_pkg::LFSR_MASK;
        rd_mask  = 32'hFFFFFFFF;
      end
    endcase
  end

  assign lfsr_next = lmte_pkg::lfsr_advance(state_i.lfsr);
  assign pat       = lfsr_next & pat_mask;
  // last when idx >= region - 1, written without the subtract
  assign idx_plus1 = CmpW'(word_cnt_i) + CmpW'(1);
  assign last      = idx_plus1 >= eff_region;
  assign mis       = (read_data_i & rd_mask) != lmte_pkg::DATA_W'(pat);
  assign idx_wide  = IdxW'(word_cnt_i);
  assign step_ok   = ((action_i == lmte_pkg::ACT_FILL) && (state_i.phase == lmte_pkg::PH_FILL))
                  || ((action_i == lmte_pkg::ACT_VERIFY)
                      && (state_i.phase == lmte_pkg::PH_VERIFY));

  always_comb begin
    state_o    = state_i;
    word_cnt_o = word_cnt_i;
    rsp_o      = '0;
    if (action_i == lmte_pkg::ACT_START) begin
      if (seed_i == '0) begin
        rsp_o.status = lmte_pkg::ST_ZERO_SEED;
      end else begin
        state_o.seed      = seed_i;
        state_o.lfsr      = seed_i;
        state_o.had_error = 1'b0;
        state_o.phase     = lmte_pkg::PH_FILL;
        word_cnt_o        = '0;
      end
    end else if (step_ok) begin
      rsp_o.word_index = idx_wide[lmte_pkg::WIDX_W-1:0];
      rsp_o.pattern    = pat;
      rsp_o.phase_last = last;
      state_o.lfsr     = lfsr_next;
      if (action_i == lmte_pkg::ACT_FILL) begin
        rsp_o.write_enable = 1'b1;
        if (last) begin
          state_o.lfsr  = state_i.seed;
          state_o.phase = lmte_pkg::PH_VERIFY;
          word_cnt_o    = '0;
        end else begin
          word_cnt_o = word_cnt_i + IndexBits'(1);
        end
      end else begin
        rsp_o.mismatch = mis;
        if (mis) begin
          state_o.errors_total = lmte_pkg::sat_inc(state_i.errors_total);
        end
        if (last) begin
          state_o.passes_done = lmte_pkg::sat_inc(state_i.passes_done);
          if (state_i.had_error || mis) begin
            state_o.failed_passes = lmte_pkg::sat_inc(state_i.failed_passes);
          end else begin
            state_o.clean_passes = lmte_pkg::sat_inc(state_i.clean_passes);
          end
          state_o.had_error = 1'b0;
          state_o.phase     = lmte_pkg::PH_IDLE;
          word_cnt_o        = '0;
        end else begin
          state_o.had_error = state_i.had_error | mis;
          word_cnt_o        = word_cnt_i + IndexBits'(1);
        end
      end
    end else begin
      rsp_o.status = lmte_pkg::ST_BAD_ACT;
    end
    rsp_o.error_count = state_o.errors_total;
    rsp_o.bad_passes  = state_o.failed_passes;
    rsp_o.good_passes = state_o.clean_passes;
    rsp_o.pass_number = state_o.passes_done;
  end

endmodule

// ----- src/lfsr_memory_test_engine_unit.sv -----
// lfsr_memory_test_engine_unit: lfsr pattern memory test sequencer, top level
// an accepted request has its result registered and valid in the cycle after acceptance
// throughput: one request per cycle while each result is taken when valid; the state
// registers and the result register are updated by the same edge, fed by the combinational step logic
// reset (async, active low): phase idle, lfsr, seed, counters cleared, no result pending
// depends on lmte_pkg, lmte_req_if, lmte_rsp_if, lmte_step
module lfsr_memory_test_engine_unit #(
  parameter int unsigned IndexBits = lmte_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lmte_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lmte_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  lmte_req_if.sink                            req_i,
  lmte_rsp_if.source                          rsp_o
);

  // configuration registers
  logic [lmte_pkg::REGION_W-1:0] region_q;
  logic [1:0]                    width_mode_q;

  // engine state
  lmte_pkg::state_t     state_q, state_d;
  logic [IndexBits-1:0] word_cnt_q, word_cnt_d;

  // result register
  lmte_pkg::rsp_t rsp_q, rsp_d;
  logic           rsp_valid_q;

  logic req_accept;

  // take a new request whenever the result slot is empty or drains this cycle
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_accept  = req_i.valid && req_i.ready;

  // plain write port, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q     <= lmte_pkg::REGION_RESET;
      width_mode_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmte_pkg::REG_REGION: region_q     <= cfg_data_i;
        lmte_pkg::REG_WIDTH:  width_mode_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  lmte_step #(
    .IndexBits (IndexBits)
  ) u_step (
    .state_i      (state_q),
    .word_cnt_i   (word_cnt_q),
    .region_i     (region_q),
    .width_mode_i (width_mode_q),
    .action_i     (req_i.action),
    .seed_i       (req_i.seed),
    .read_data_i  (req_i.read_data),
    .state_o      (state_d),
    .word_cnt_o   (word_cnt_d),
    .rsp_o        (rsp_d)
  );

  // state only moves on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= '0;
      word_cnt_q <= '0;
    end else if (req_accept) begin
      state_q    <= state_d;
      word_cnt_q <= word_cnt_d;
    end
  end

  // result valid flag: set by an accepted request, cleared once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.word_index   = rsp_q.word_index;
  assign rsp_o.pattern      = rsp_q.pattern;
  assign rsp_o.write_enable = rsp_q.write_enable;
  assign rsp_o.mismatch     = rsp_q.mismatch;
  assign rsp_o.phase_last   = rsp_q.phase_last;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.error_count  = rsp_q.error_count;
  assign rsp_o.bad_passes   = rsp_q.bad_passes;
  assign rsp_o.good_passes  = rsp_q.good_passes;
  assign rsp_o.pass_number  = rsp_q.pass_number;

endmodule
